>>> rtl/lsc_pkg.sv
package lsc_pkg;

  // Frame geometry and arithmetic widths
  localparam int unsigned SAMPLE_BITS = 12;
  localparam int unsigned NUM_SENSORS = 8;
  localparam int unsigned READ_BITS   = SAMPLE_BITS + 1;
  localparam int unsigned PROD_BITS   = READ_BITS + 4;
  localparam int unsigned TOTAL_BITS  = READ_BITS + $clog2(NUM_SENSORS);
  localparam int unsigned WSUM_BITS   = READ_BITS + 5;
  localparam int unsigned SCALE_SHIFT = 10;
  localparam int unsigned DVD_BITS    = WSUM_BITS - 1 + SCALE_SHIFT;
  localparam int unsigned DIV_STEPS   = DVD_BITS;
  localparam int unsigned CNT_BITS    = $clog2(DIV_STEPS + 1);
  localparam int unsigned POS_BITS    = 14;

  typedef logic [READ_BITS-1:0]         read_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] sample_7;
    logic [SAMPLE_BITS-1:0] sample_6;
    logic [SAMPLE_BITS-1:0] sample_5;
    logic [SAMPLE_BITS-1:0] sample_4;
    logic [SAMPLE_BITS-1:0] sample_3;
    logic [SAMPLE_BITS-1:0] sample_2;
    logic [SAMPLE_BITS-1:0] sample_1;
    logic [SAMPLE_BITS-1:0] sample_0;
  } in_req_t;

  typedef struct packed {
    logic signed [POS_BITS-1:0] position;
    logic                       held;
  } out_req_t;

  // Handshake between sequencer and divider
  typedef struct packed {
    logic                start;
    logic [DVD_BITS-1:0] dividend;
    logic [TOTAL_BITS-1:0] divisor;
  } div_cmd_t;

  // Sensor weight: -7, -5, ... +7 from left to right
  function automatic prod_t sensor_weight(input int unsigned idx);
    sensor_weight = PROD_BITS'(2 * int'(idx) - 7);
  endfunction

endpackage

>>> rtl/lsc_lane.sv
module lsc_lane
  import lsc_pkg::*;
#(
  parameter int unsigned LANE = 0
) (
  input  logic                   clk,
  input  logic                   load,
  input  logic                   dark,
  input  logic [SAMPLE_BITS-1:0] sample,
  output read_t                  read_out,
  output prod_t                  prod_out
);

  localparam prod_t WEIGHT = sensor_weight(LANE);

  read_t read_nxt;
  prod_t prod_nxt;
  read_t read_r;
  prod_t prod_r;

  // Invert for dark line, then weight
  always_comb begin
    if (dark) begin
      read_nxt = (READ_BITS'(1) << SAMPLE_BITS) - {1'b0, sample};
    end else begin
      read_nxt = {1'b0, sample};
    end
    prod_nxt = $signed({{(PROD_BITS - READ_BITS){1'b0}}, read_nxt}) * WEIGHT;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      read_r <= read_nxt;
      prod_r <= prod_nxt;
    end
  end

  assign read_out = read_r;
  assign prod_out = prod_r;

endmodule

>>> rtl/lsc_merge.sv
module lsc_merge
  import lsc_pkg::*;
(
  input  logic                                   clk,
  input  logic                                   load,
  input  read_t [NUM_SENSORS-1:0]                reads,
  input  prod_t [NUM_SENSORS-1:0]                prods,
  output logic [TOTAL_BITS-1:0]                  total,
  output logic signed [WSUM_BITS-1:0]            wsum
);

  logic [TOTAL_BITS-1:0]       total_nxt;
  logic signed [WSUM_BITS-1:0] wsum_nxt;
  logic [TOTAL_BITS-1:0]       total_r;
  logic signed [WSUM_BITS-1:0] wsum_r;

  // Add up plain and weighted readings of all lanes
  always_comb begin
    total_nxt = '0;
    wsum_nxt  = '0;
    for (int i = 0; i < NUM_SENSORS; i++) begin
      total_nxt = total_nxt + TOTAL_BITS'(reads[i]);
      wsum_nxt  = wsum_nxt + WSUM_BITS'(prods[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      total_r <= total_nxt;
      wsum_r  <= wsum_nxt;
    end
  end

  assign total = total_r;
  assign wsum  = wsum_r;

endmodule

>>> rtl/lsc_div.sv
module lsc_div
  import lsc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  div_cmd_t            cmd,
  output logic                done,
  output logic [POS_BITS-1:0] quotient
);

  logic [TOTAL_BITS-1:0] rem_r;
  logic [DVD_BITS-1:0]   quo_r;
  logic [TOTAL_BITS-1:0] dvs_r;
  logic [CNT_BITS-1:0]   cnt_r;
  logic                  done_r;

  logic [TOTAL_BITS:0]   trial;
  logic [TOTAL_BITS:0]   diff;
  logic                  fits;

  // One restoring step: shift in a dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, quo_r[DVD_BITS-1]};
    diff  = trial - {1'b0, dvs_r};
    fits  = trial >= {1'b0, dvs_r};
  end

  // Control: step counter and completion pulse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else if (cmd.start) begin
      cnt_r  <= CNT_BITS'(DIV_STEPS);
      done_r <= 1'b0;
    end else begin
      done_r <= (cnt_r == CNT_BITS'(1));
      if (cnt_r != '0) begin
        cnt_r <= cnt_r - CNT_BITS'(1);
      end
    end
  end

  // Datapath: remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem_r <= '0;
      quo_r <= cmd.dividend;
      dvs_r <= cmd.divisor;
    end else if (cnt_r != '0) begin
      rem_r <= fits ? diff[TOTAL_BITS-1:0] : trial[TOTAL_BITS-1:0];
      quo_r <= {quo_r[DVD_BITS-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r[POS_BITS-1:0];

endmodule

>>> rtl/line_sensor_centroid_core.sv
// Line position from one frame of eight sensor readings, as the weighted
// centroid times 1024 (signed, truncated toward zero). A frame is taken when
// in_valid and in_ready are both high; the block works on one frame at a time.
// The eight lanes invert and weight the readings as the frame is taken, then
// the merge adds them up, a setup state starts the divide, the serial divider
// makes one quotient bit per cycle, the sign is applied and the result loads
// the output register, after which the next frame can be taken. A frame whose
// readings sum to zero skips the divider and repeats the last position with
// held set. The output register lets the next frame enter while a result
// still waits for out_ready.
// cfg_wdata selects dark-line-on-light mode (reset 1). The user must write it
// only while no frame is in progress; the block itself does not enforce this.
module line_sensor_centroid_core
  import lsc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data,
  input  logic     cfg_we,
  input  logic     cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SUM   = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                 state_r, state_nxt;
  logic                       dark_r;
  logic signed [POS_BITS-1:0] last_pos_r;
  logic signed [POS_BITS-1:0] res_pos_r;
  logic                       res_held_r;
  logic                       neg_r;
  logic                       out_valid_r, out_valid_nxt;
  out_req_t                   out_data_r;

  logic                         in_acc;
  logic                         out_load;
  logic [SAMPLE_BITS-1:0]       samples [NUM_SENSORS];
  read_t [NUM_SENSORS-1:0]      reads;
  prod_t [NUM_SENSORS-1:0]      prods;
  logic [TOTAL_BITS-1:0]        total;
  logic signed [WSUM_BITS-1:0]  wsum;
  logic [WSUM_BITS-2:0]         wmag;
  div_cmd_t                     div_cmd;
  logic                         div_done;
  logic [POS_BITS-1:0]          div_quo;

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  assign samples[0] = in_data.sample_0;
  assign samples[1] = in_data.sample_1;
  assign samples[2] = in_data.sample_2;
  assign samples[3] = in_data.sample_3;
  assign samples[4] = in_data.sample_4;
  assign samples[5] = in_data.sample_5;
  assign samples[6] = in_data.sample_6;
  assign samples[7] = in_data.sample_7;

  // Eight weighting lanes
  for (genvar g = 0; g < NUM_SENSORS; g++) begin : g_lane
    lsc_lane #(.LANE(g)) u_lane (
      .clk      (clk),
      .load     (in_acc),
      .dark     (dark_r),
      .sample   (samples[g]),
      .read_out (reads[g]),
      .prod_out (prods[g])
    );
  end

  lsc_merge u_merge (
    .clk   (clk),
    .load  (state_r == S_SUM),
    .reads (reads),
    .prods (prods),
    .total (total),
    .wsum  (wsum)
  );

  // Magnitude of weighted sum, scaled by 1024, goes to the divider
  always_comb begin
    wmag             = wsum[WSUM_BITS-1] ? (WSUM_BITS-1)'(-wsum) : (WSUM_BITS-1)'(wsum);
    div_cmd.start    = (state_r == S_START) && (total != '0);
    div_cmd.dividend = {wmag, {SCALE_SHIFT{1'b0}}};
    div_cmd.divisor  = total;
  end

  lsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Sequence one frame through lanes, merge and divider
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_acc) state_nxt = S_SUM;
      S_SUM:   state_nxt = S_START;
      S_START: state_nxt = (total == '0) ? S_DONE : S_DIV;
      S_DIV:   if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and kept position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      dark_r      <= 1'b1;
      last_pos_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        dark_r <= cfg_wdata;
      end
      if (out_load && !res_held_r) begin
        last_pos_r <= res_pos_r;
      end
    end
  end

  // Result capture and output register
  always_ff @(posedge clk) begin
    if (state_r == S_START) begin
      neg_r      <= wsum[WSUM_BITS-1];
      res_pos_r  <= last_pos_r;
      res_held_r <= (total == '0);
    end else if (state_r == S_DIV && div_done) begin
      res_pos_r  <= neg_r ? -$signed(div_quo) : $signed(div_quo);
    end
    if (out_load) begin
      out_data_r.position <= res_pos_r;
      out_data_r.held     <= res_held_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/lsc_chk.sv
module lsc_chk
  import lsc_pkg::*;
(
  input logic     clk,
  input logic     rst_n,
  input logic     in_valid,
  input logic     in_ready,
  input logic     out_valid,
  input logic     out_ready,
  input out_req_t out_data
);

  logic                       in_acc;
  logic                       out_acc;
  logic [1:0]                 pend_r;
  logic signed [POS_BITS-1:0] last_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Track requests in flight and the last delivered position
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
      last_r <= '0;
    end else begin
      pend_r <= pend_r + 2'(in_acc) - 2'(out_acc);
      if (out_acc) begin
        last_r <= out_data.position;
      end
    end
  end

  a_held_repeats: assert property (@(posedge clk) disable iff (!rst_n)
    out_acc && out_data.held |-> out_data.position == last_r)
    else $error("held result does not repeat last position");

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.position >= -14'sd7168) && (out_data.position <= 14'sd7168))
    else $error("position out of range");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result without a request");

  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r <= 2'd2)
    else $error("too many requests in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind line_sensor_centroid_core lsc_chk u_lsc_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
